// File: src/lwfs_pkg.sv
// Shared types and constants for the LCD window fill sequencer.
package lwfs_pkg;

    localparam int SCREEN_WIDTH  = 128;
    localparam int SCREEN_HEIGHT = 160;

    localparam int COL_W = $clog2(SCREEN_WIDTH + 1);
    localparam int ROW_W = $clog2(SCREEN_HEIGHT + 1);
    localparam int PIX_W = $clog2(SCREEN_WIDTH * SCREEN_HEIGHT + 1);

    localparam logic [7:0] CMD_COLSET   = 8'h2A;
    localparam logic [7:0] CMD_ROWSET   = 8'h2B;
    localparam logic [7:0] CMD_MEMWRITE = 8'h2C;

    typedef enum logic [1:0] {
        MODE_FILL    = 2'd0,
        MODE_IMAGE   = 2'd1,
        MODE_ADVANCE = 2'd2,
        MODE_ILLEGAL = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_BUSY    = 2'd1,
        STATUS_INVALID = 2'd2
    } status_t;

    typedef enum logic {
        REG_COLUMN_OFFSET = 1'b0,
        REG_ROW_OFFSET    = 1'b1
    } reg_index_t;

    typedef enum logic [1:0] {
        OP_START   = 2'd0,
        OP_ADVANCE = 2'd1,
        OP_ILLEGAL = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_COL_DATA = 3'd1,
        PH_ROW_CMD  = 3'd2,
        PH_ROW_DATA = 3'd3,
        PH_MEM_CMD  = 3'd4,
        PH_PIXELS   = 3'd5
    } phase_t;

    // classified word handed from front to back
    typedef struct packed {
        op_t              op;
        logic             start_ok;
        logic             image;
        logic [15:0]      col_start;
        logic [15:0]      col_end;
        logic [15:0]      row_start;
        logic [15:0]      row_end;
        logic [15:0]      color;
        logic [PIX_W-1:0] pixels;
        logic [7:0]       image_byte;
    } cmd_t;

    typedef struct packed {
        status_t    status;
        logic       byte_valid;
        logic [7:0] spi_byte;
        logic       is_data;
        logic       job_done;
        logic       busy_res;
    } res_t;

endpackage

// File: src/lwfs_front.sv
// Front end: offset registers and start-request checks, window and pixel count.
module lwfs_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [0:0]        cfg_index,
    input  logic [7:0]        cfg_data,
    input  logic [1:0]        mode,
    input  logic [15:0]       rect_x,
    input  logic [15:0]       rect_y,
    input  logic [15:0]       rect_w,
    input  logic [15:0]       rect_h,
    input  logic [15:0]       paint_color,
    input  logic [7:0]        image_byte,
    output lwfs_pkg::cmd_t    cmd
);

    localparam logic [16:0] SCR_W = 17'(lwfs_pkg::SCREEN_WIDTH);
    localparam logic [16:0] SCR_H = 17'(lwfs_pkg::SCREEN_HEIGHT);

    logic [7:0]  col_off_reg;
    logic [7:0]  row_off_reg;
    logic [16:0] sum_x;
    logic [16:0] sum_y;
    logic [15:0] wc;
    logic [15:0] hc;
    logic        on_screen;
    logic        fits;
    logic        is_fill;
    logic [lwfs_pkg::COL_W+lwfs_pkg::ROW_W-1:0] prod;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_off_reg <= 8'd0;
            row_off_reg <= 8'd0;
        end
        else if (cfg_we)
        begin
            unique case (lwfs_pkg::reg_index_t'(cfg_index))
                lwfs_pkg::REG_COLUMN_OFFSET: col_off_reg <= cfg_data;
                lwfs_pkg::REG_ROW_OFFSET:    row_off_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        is_fill   = (lwfs_pkg::mode_t'(mode) == lwfs_pkg::MODE_FILL);
        sum_x     = {1'b0, rect_x} + {1'b0, rect_w};
        sum_y     = {1'b0, rect_y} + {1'b0, rect_h};
        on_screen = ({1'b0, rect_x} < SCR_W) && ({1'b0, rect_y} < SCR_H);
        fits      = (sum_x <= SCR_W) && (sum_y <= SCR_H);
        // fills are clipped to the screen edge
        wc = (is_fill && sum_x > SCR_W) ? 16'(SCR_W - {1'b0, rect_x}) : rect_w;
        hc = (is_fill && sum_y > SCR_H) ? 16'(SCR_H - {1'b0, rect_y}) : rect_h;
        // only meaningful when the window is accepted, then wc/hc fit the screen
        prod = wc[lwfs_pkg::COL_W-1:0] * hc[lwfs_pkg::ROW_W-1:0];

        unique case (lwfs_pkg::mode_t'(mode)) inside
            lwfs_pkg::MODE_FILL,
            lwfs_pkg::MODE_IMAGE:   cmd.op = lwfs_pkg::OP_START;
            lwfs_pkg::MODE_ADVANCE: cmd.op = lwfs_pkg::OP_ADVANCE;
            default:                cmd.op = lwfs_pkg::OP_ILLEGAL;
        endcase

        cmd.start_ok   = on_screen && (is_fill || fits) && (wc != 16'd0) && (hc != 16'd0);
        cmd.image      = !is_fill;
        cmd.col_start  = rect_x + {8'd0, col_off_reg};
        cmd.row_start  = rect_y + {8'd0, row_off_reg};
        cmd.col_end    = rect_x + wc - 16'd1 + {8'd0, col_off_reg};
        cmd.row_end    = rect_y + hc - 16'd1 + {8'd0, row_off_reg};
        cmd.color      = paint_color;
        cmd.pixels     = lwfs_pkg::PIX_W'(prod);
        cmd.image_byte = image_byte;
    end

endmodule

// File: src/lwfs_queue.sv
// Two-entry queue of classified words between front and back.
module lwfs_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  lwfs_pkg::cmd_t push_cmd,
    input  logic           pop,
    output logic           full,
    output logic           head_valid,
    output lwfs_pkg::cmd_t head_cmd
);

    lwfs_pkg::cmd_t entry_reg [2];
    logic [1:0]     count_reg;
    logic [1:0]     count_next;
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_cmd   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

// File: src/lwfs_back.sv
// Back end: window-write sequencer and the result register.
module lwfs_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           head_valid,
    input  lwfs_pkg::cmd_t head_cmd,
    output logic           pop,
    output logic           res_valid,
    input  logic           res_ready,
    output lwfs_pkg::res_t res
);

    lwfs_pkg::phase_t            phase_reg, phase_next;
    logic [1:0]                  byte_index_reg, byte_index_next;
    logic                        image_job_reg, image_job_next;
    logic [15:0]                 col_start_reg, col_start_next;
    logic [15:0]                 col_end_reg, col_end_next;
    logic [15:0]                 row_start_reg, row_start_next;
    logic [15:0]                 row_end_reg, row_end_next;
    logic [15:0]                 color_reg, color_next;
    logic [lwfs_pkg::PIX_W-1:0]  pixels_left_reg, pixels_left_next;
    logic                        low_byte_next_reg, low_byte_next_next;
    logic                        res_valid_reg;
    lwfs_pkg::res_t              res_reg, res_now;
    logic                        job_active;
    logic                        last_pixel;

    function automatic logic [7:0] window_byte(input logic [15:0] s, input logic [15:0] e,
                                               input logic [1:0] idx);
        case (idx)
            2'd0:    window_byte = s[15:8];
            2'd1:    window_byte = s[7:0];
            2'd2:    window_byte = e[15:8];
            default: window_byte = e[7:0];
        endcase
    endfunction

    assign job_active = (phase_reg != lwfs_pkg::PH_IDLE);
    assign pop        = head_valid && (!res_valid_reg || res_ready);
    assign res_valid  = res_valid_reg;
    assign res        = res_reg;
    assign last_pixel = low_byte_next_reg && (pixels_left_reg <= lwfs_pkg::PIX_W'(1));

    // next state
    always_comb
    begin
        phase_next         = phase_reg;
        byte_index_next    = byte_index_reg;
        image_job_next     = image_job_reg;
        col_start_next     = col_start_reg;
        col_end_next       = col_end_reg;
        row_start_next     = row_start_reg;
        row_end_next       = row_end_reg;
        color_next         = color_reg;
        pixels_left_next   = pixels_left_reg;
        low_byte_next_next = low_byte_next_reg;
        unique case (head_cmd.op)
            lwfs_pkg::OP_START:
            begin
                if (!job_active && head_cmd.start_ok)
                begin
                    col_start_next     = head_cmd.col_start;
                    col_end_next       = head_cmd.col_end;
                    row_start_next     = head_cmd.row_start;
                    row_end_next       = head_cmd.row_end;
                    image_job_next     = head_cmd.image;
                    if (!head_cmd.image)
                        color_next = head_cmd.color;
                    pixels_left_next   = head_cmd.pixels;
                    low_byte_next_next = 1'b0;
                    byte_index_next    = 2'd0;
                    phase_next         = lwfs_pkg::PH_COL_DATA;
                end
            end
            lwfs_pkg::OP_ADVANCE:
            begin
                unique case (phase_reg)
                    lwfs_pkg::PH_COL_DATA:
                    begin
                        byte_index_next = byte_index_reg + 2'd1;
                        if (byte_index_reg == 2'd3)
                            phase_next = lwfs_pkg::PH_ROW_CMD;
                    end
                    lwfs_pkg::PH_ROW_CMD: phase_next = lwfs_pkg::PH_ROW_DATA;
                    lwfs_pkg::PH_ROW_DATA:
                    begin
                        byte_index_next = byte_index_reg + 2'd1;
                        if (byte_index_reg == 2'd3)
                            phase_next = lwfs_pkg::PH_MEM_CMD;
                    end
                    lwfs_pkg::PH_MEM_CMD:
                    begin
                        phase_next         = lwfs_pkg::PH_PIXELS;
                        low_byte_next_next = 1'b0;
                    end
                    lwfs_pkg::PH_PIXELS:
                    begin
                        low_byte_next_next = !low_byte_next_reg;
                        if (low_byte_next_reg)
                        begin
                            if (pixels_left_reg != '0)
                                pixels_left_next = pixels_left_reg - lwfs_pkg::PIX_W'(1);
                            if (last_pixel)
                                phase_next = lwfs_pkg::PH_IDLE;
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    // result of the head word
    always_comb
    begin
        res_now.status     = lwfs_pkg::STATUS_OK;
        res_now.byte_valid = 1'b0;
        res_now.spi_byte   = 8'd0;
        res_now.is_data    = 1'b0;
        res_now.job_done   = 1'b0;
        res_now.busy_res   = (phase_next != lwfs_pkg::PH_IDLE);
        unique case (head_cmd.op)
            lwfs_pkg::OP_START:
            begin
                if (job_active)
                    res_now.status = lwfs_pkg::STATUS_BUSY;
                else if (!head_cmd.start_ok)
                    res_now.status = lwfs_pkg::STATUS_INVALID;
                else
                begin
                    res_now.byte_valid = 1'b1;
                    res_now.spi_byte   = lwfs_pkg::CMD_COLSET;
                end
            end
            lwfs_pkg::OP_ADVANCE:
            begin
                res_now.byte_valid = job_active;
                unique case (phase_reg)
                    lwfs_pkg::PH_COL_DATA:
                    begin
                        res_now.spi_byte = window_byte(col_start_reg, col_end_reg,
                                                       byte_index_reg);
                        res_now.is_data  = 1'b1;
                    end
                    lwfs_pkg::PH_ROW_CMD: res_now.spi_byte = lwfs_pkg::CMD_ROWSET;
                    lwfs_pkg::PH_ROW_DATA:
                    begin
                        res_now.spi_byte = window_byte(row_start_reg, row_end_reg,
                                                       byte_index_reg);
                        res_now.is_data  = 1'b1;
                    end
                    lwfs_pkg::PH_MEM_CMD: res_now.spi_byte = lwfs_pkg::CMD_MEMWRITE;
                    lwfs_pkg::PH_PIXELS:
                    begin
                        res_now.is_data = 1'b1;
                        if (image_job_reg)
                            res_now.spi_byte = head_cmd.image_byte;
                        else if (low_byte_next_reg)
                            res_now.spi_byte = color_reg[7:0];
                        else
                            res_now.spi_byte = color_reg[15:8];
                        res_now.job_done = last_pixel;
                    end
                    default: ;
                endcase
            end
            default: res_now.status = lwfs_pkg::STATUS_INVALID;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= lwfs_pkg::PH_IDLE;
            byte_index_reg    <= 2'd0;
            image_job_reg     <= 1'b0;
            col_start_reg     <= 16'd0;
            col_end_reg       <= 16'd0;
            row_start_reg     <= 16'd0;
            row_end_reg       <= 16'd0;
            color_reg         <= 16'd0;
            pixels_left_reg   <= '0;
            low_byte_next_reg <= 1'b0;
            res_valid_reg     <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                phase_reg         <= phase_next;
                byte_index_reg    <= byte_index_next;
                image_job_reg     <= image_job_next;
                col_start_reg     <= col_start_next;
                col_end_reg       <= col_end_next;
                row_start_reg     <= row_start_next;
                row_end_reg       <= row_end_next;
                color_reg         <= color_next;
                pixels_left_reg   <= pixels_left_next;
                low_byte_next_reg <= low_byte_next_next;
            end
            if (pop)
                res_valid_reg <= 1'b1;
            else if (res_ready)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            res_reg <= res_now;
    end

    // pixel phase never runs on an empty count
    a_pixels_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == lwfs_pkg::PH_PIXELS) |-> (pixels_left_reg != '0))
        else $error("pixel phase with zero pixels left");

    // byte counter moves only inside the window data phases
    a_index_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (byte_index_reg != 2'd0) |->
            (phase_reg == lwfs_pkg::PH_COL_DATA || phase_reg == lwfs_pkg::PH_ROW_DATA))
        else $error("byte index outside window data phases");

    // a finished job leaves the sequencer idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && res_now.job_done) |=> (phase_reg == lwfs_pkg::PH_IDLE && res_reg.is_data))
        else $error("job done but sequencer not idle");

    // a busy rejection only happens while a job runs
    a_busy_active: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && res_now.status == lwfs_pkg::STATUS_BUSY) |-> job_active)
        else $error("busy status while idle");

endmodule

// File: src/lcd_window_fill_sequencer_top.sv
// Top level of the LCD window fill sequencer.
//
// Input channel (in_valid/in_ready) takes one request word per cycle while
// in_ready is high: a fill start, image start or advance. Each word yields
// exactly one result word on the output channel (out_valid/out_ready): status,
// the link byte with its data/command level, the job-done flag and the busy
// flag after the word. An accepted start emits the column-set command; each
// advance in a job emits the next window-setup byte, then the pixel stream:
// the RGB565 fill color, high byte first, or the word's image byte. Each word
// is registered in the two-entry queue, then passes the sequencer into the
// result register. Throughput is one word per cycle when not stalled.
// When the receiver stalls, the result register holds, the queue fills and
// in_ready drops once both queue entries are taken.
// Offsets are written through cfg_we/cfg_index/cfg_data while the block idles;
// the user must keep to this, the block does not enforce it. Reset clears
// the queue, the result valid flag, the offsets and the sequencer (no job active).
module lcd_window_fill_sequencer_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  mode,
    input  logic [15:0] rect_x,
    input  logic [15:0] rect_y,
    input  logic [15:0] rect_w,
    input  logic [15:0] rect_h,
    input  logic [15:0] paint_color,
    input  logic [7:0]  image_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic        byte_valid,
    output logic [7:0]  spi_byte,
    output logic        is_data,
    output logic        job_done,
    output logic        busy_res
);

    lwfs_pkg::cmd_t front_cmd;
    lwfs_pkg::cmd_t head_cmd;
    lwfs_pkg::res_t res;
    logic           full;
    logic           head_valid;
    logic           pop;

    assign in_ready = !full;

    lwfs_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mode        (mode),
        .rect_x      (rect_x),
        .rect_y      (rect_y),
        .rect_w      (rect_w),
        .rect_h      (rect_h),
        .paint_color (paint_color),
        .image_byte  (image_byte),
        .cmd         (front_cmd)
    );

    lwfs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (in_valid && !full),
        .push_cmd   (front_cmd),
        .pop        (pop),
        .full       (full),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    lwfs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .res_valid  (out_valid),
        .res_ready  (out_ready),
        .res        (res)
    );

    assign status     = res.status;
    assign byte_valid = res.byte_valid;
    assign spi_byte   = res.spi_byte;
    assign is_data    = res.is_data;
    assign job_done   = res.job_done;
    assign busy_res   = res.busy_res;

endmodule
